[design/cpbf_pkg.sv]
package cpbf_pkg;

    // Fixed field widths of the point and result beats
    localparam int unsigned FIELD_W = 16;
    localparam int unsigned ID_W    = 16;
    localparam int unsigned DIST_W  = 33;

    typedef enum logic [3:0] {
        S_IDLE,     // loading points
        S_RDI,      // fetch outer point i
        S_LDI,      // latch point i, fetch point j
        S_RDJ,      // fetch inner point j
        S_DIFF,     // absolute differences
        S_SQX,      // dx squared
        S_SQY,      // plus dy squared
        S_CMP,      // compare against best, step indices
        S_FIN       // hand result to output register
    } t_state;

    // Step enables for the shared distance datapath
    typedef struct packed {
        logic diff_en;
        logic sqx_en;
        logic sqy_en;
    } t_dist_ctl;

endpackage

[design/cpbf_dist_unit.sv]
// Shared squared-distance datapath: one subtract pair, one multiplier,
// one adder. Three steps per pair under control of the sequencer.
module cpbf_dist_unit #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                        i_clk,
    input  cpbf_pkg::t_dist_ctl         i_ctl,
    input  logic [COORD_BITS-1:0]       i_xa,
    input  logic [COORD_BITS-1:0]       i_ya,
    input  logic [COORD_BITS-1:0]       i_xb,
    input  logic [COORD_BITS-1:0]       i_yb,
    output logic [2*COORD_BITS+2:0]     o_dist
);

    localparam int unsigned DW    = COORD_BITS + 1;
    localparam int unsigned PRD_W = 2 * DW;
    localparam int unsigned SUM_W = PRD_W + 1;

    logic signed [DW-1:0] w_dx_s;
    logic signed [DW-1:0] w_dy_s;
    logic [DW-1:0]        w_dx_abs;
    logic [DW-1:0]        w_dy_abs;
    logic [DW-1:0]        w_mul_op;
    logic [PRD_W-1:0]     w_prod;

    logic [DW-1:0]        r_dx;
    logic [DW-1:0]        r_dy;
    logic [PRD_W-1:0]     r_acc;
    logic [SUM_W-1:0]     r_dist;

    assign w_dx_s = $signed({i_xa[COORD_BITS-1], i_xa}) - $signed({i_xb[COORD_BITS-1], i_xb});
    assign w_dy_s = $signed({i_ya[COORD_BITS-1], i_ya}) - $signed({i_yb[COORD_BITS-1], i_yb});
    assign w_dx_abs = w_dx_s[DW-1] ? DW'(-w_dx_s) : DW'(w_dx_s);
    assign w_dy_abs = w_dy_s[DW-1] ? DW'(-w_dy_s) : DW'(w_dy_s);

    // single multiplier, squares dx then dy
    assign w_mul_op = i_ctl.sqx_en ? r_dx : r_dy;
    assign w_prod   = w_mul_op * w_mul_op;

    always_ff @(posedge i_clk) begin
        if (i_ctl.diff_en) begin
            r_dx <= w_dx_abs;
            r_dy <= w_dy_abs;
        end
        if (i_ctl.sqx_en) begin
            r_acc <= w_prod;
        end
        if (i_ctl.sqy_en) begin
            r_dist <= SUM_W'(r_acc) + SUM_W'(w_prod);
        end
    end

    assign o_dist = r_dist;

endmodule

[design/closest_pair_brute_force.sv]
// Channel  | Handshake                  | Beat contents
// ---------+----------------------------+-----------------------------------------
// point in | i_in_valid / o_in_ready    | i_x, i_y, i_point_id, i_last
// result   | o_out_valid / i_out_ready  | o_found, o_first_id, o_second_id,
//          |                            | o_dist_sq, o_overflow
//
// Points load at one beat per cycle into a point store with one write and
// one read port. A beat with i_last closes the set and, with two or more
// points stored, starts the all-pairs search; o_in_ready is low until the
// result goes to the output register. Each pair runs through the one shared
// multiplier as fetch j, differences, dx^2, +dy^2, compare, and each new
// outer point adds its own fetch; the search time is set by the multiplier
// and the store's single read port. The result sits in an output register,
// so the next set may load while it waits; a search ending with the previous
// result untaken waits in S_FIN. Synchronous active-low reset; no clearing pass.
module closest_pair_brute_force #(
    parameter int unsigned MAX_POINTS = 256,
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // point channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [cpbf_pkg::FIELD_W-1:0]  i_x,
    input  logic [cpbf_pkg::FIELD_W-1:0]  i_y,
    input  logic [cpbf_pkg::ID_W-1:0]     i_point_id,
    input  logic                          i_last,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [cpbf_pkg::ID_W-1:0]     o_first_id,
    output logic [cpbf_pkg::ID_W-1:0]     o_second_id,
    output logic [cpbf_pkg::DIST_W-1:0]   o_dist_sq,
    output logic                          o_overflow
);

    localparam int unsigned CB    = COORD_BITS;
    localparam int unsigned ID_W  = cpbf_pkg::ID_W;
    localparam int unsigned AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
    localparam int unsigned PW    = 2 * CB + ID_W;   // {id, y, x}
    localparam int unsigned SUM_W = 2 * CB + 3;

    // point store
    logic [PW-1:0]        r_mem [MAX_POINTS];
    logic [PW-1:0]        r_rd;
    logic [AW-1:0]        w_raddr;
    logic                 w_wr;
    logic [PW-1:0]        w_wdata;

    // sequencer state
    cpbf_pkg::t_state     r_state, n_state;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_drop, n_drop;
    logic [CNT_W-1:0]     r_i, n_i;
    logic [CNT_W-1:0]     r_j, n_j;
    logic                 r_taken, n_taken;
    logic [PW-1:0]        r_pi, n_pi;
    logic [ID_W-1:0]      r_jid, n_jid;
    logic [SUM_W-1:0]     r_best, n_best;
    logic [ID_W-1:0]      r_bfirst, n_bfirst;
    logic [ID_W-1:0]      r_bsecond, n_bsecond;

    // output register
    logic                 r_ovalid, n_ovalid;
    logic                 r_found, n_found;
    logic [ID_W-1:0]      r_ofirst, n_ofirst;
    logic [ID_W-1:0]      r_osecond, n_osecond;
    logic [cpbf_pkg::DIST_W-1:0] r_odist, n_odist;
    logic                 r_oflow, n_oflow;

    cpbf_pkg::t_dist_ctl  w_ctl;
    logic [SUM_W-1:0]     w_dist;
    logic                 w_in_acc;
    logic                 w_stored;
    logic [CNT_W-1:0]     w_cnt_after;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_stored    = (r_cnt < CNT_W'(MAX_POINTS));
    assign w_cnt_after = w_stored ? (r_cnt + CNT_W'(1)) : r_cnt;
    // coordinates above COORD_BITS ignored; missing bits read as zero
    assign w_wdata = {i_point_id, CB'({16'b0, i_y}), CB'({16'b0, i_x})};
    assign w_wr    = w_in_acc && w_stored;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_cnt[AW-1:0]] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    cpbf_dist_unit #(
        .COORD_BITS (CB)
    ) u_dist (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_xa   (r_pi[CB-1:0]),
        .i_ya   (r_pi[2*CB-1:CB]),
        .i_xb   (r_rd[CB-1:0]),
        .i_yb   (r_rd[2*CB-1:CB]),
        .o_dist (w_dist)
    );

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_drop    = r_drop;
        n_i       = r_i;
        n_j       = r_j;
        n_taken   = r_taken;
        n_pi      = r_pi;
        n_jid     = r_jid;
        n_best    = r_best;
        n_bfirst  = r_bfirst;
        n_bsecond = r_bsecond;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_found   = r_found;
        n_ofirst  = r_ofirst;
        n_osecond = r_osecond;
        n_odist   = r_odist;
        n_oflow   = r_oflow;
        w_raddr   = r_j[AW-1:0];
        w_ctl     = '0;
        o_in_ready = 1'b0;

        unique case (r_state)
            cpbf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (w_in_acc) begin
                    n_cnt  = w_cnt_after;
                    n_drop = r_drop || !w_stored;
                    if (i_last) begin
                        n_i     = '0;
                        n_taken = 1'b0;
                        n_state = (w_cnt_after >= CNT_W'(2)) ? cpbf_pkg::S_RDI
                                                             : cpbf_pkg::S_FIN;
                    end
                end
            end
            cpbf_pkg::S_RDI: begin
                w_raddr = r_i[AW-1:0];
                n_j     = r_i + CNT_W'(1);
                n_state = cpbf_pkg::S_LDI;
            end
            cpbf_pkg::S_LDI: begin
                n_pi    = r_rd;
                n_state = cpbf_pkg::S_DIFF;
            end
            cpbf_pkg::S_RDJ: begin
                n_state = cpbf_pkg::S_DIFF;
            end
            cpbf_pkg::S_DIFF: begin
                w_ctl.diff_en = 1'b1;
                n_jid   = r_rd[PW-1:2*CB];
                n_state = cpbf_pkg::S_SQX;
            end
            cpbf_pkg::S_SQX: begin
                w_ctl.sqx_en = 1'b1;
                n_state = cpbf_pkg::S_SQY;
            end
            cpbf_pkg::S_SQY: begin
                w_ctl.sqy_en = 1'b1;
                n_state = cpbf_pkg::S_CMP;
            end
            cpbf_pkg::S_CMP: begin
                // first pair always taken; later ones only if strictly closer
                if (!r_taken || (w_dist < r_best)) begin
                    n_taken   = 1'b1;
                    n_best    = w_dist;
                    n_bfirst  = r_pi[PW-1:2*CB];
                    n_bsecond = r_jid;
                end
                priority if ((r_j + CNT_W'(1)) < r_cnt) begin
                    n_j     = r_j + CNT_W'(1);
                    n_state = cpbf_pkg::S_RDJ;
                end else if (({1'b0, r_i} + (CNT_W+1)'(2)) < {1'b0, r_cnt}) begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = cpbf_pkg::S_RDI;
                end else begin
                    n_state = cpbf_pkg::S_FIN;
                end
            end
            cpbf_pkg::S_FIN: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_oflow  = r_drop;
                    if (r_cnt >= CNT_W'(2)) begin
                        n_found   = 1'b1;
                        n_ofirst  = r_bfirst;
                        n_osecond = r_bsecond;
                        n_odist   = cpbf_pkg::DIST_W'(r_best);
                    end else begin
                        n_found   = 1'b0;
                        n_ofirst  = '0;
                        n_osecond = '0;
                        n_odist   = '0;
                    end
                    n_cnt     = '0;
                    n_drop    = 1'b0;
                    n_taken   = 1'b0;
                    n_bfirst  = '0;
                    n_bsecond = '0;
                    n_state   = cpbf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cpbf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cpbf_pkg::S_IDLE;
            r_cnt     <= '0;
            r_drop    <= 1'b0;
            r_taken   <= 1'b0;
            r_ovalid  <= 1'b0;
            r_bfirst  <= '0;
            r_bsecond <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_drop    <= n_drop;
            r_taken   <= n_taken;
            r_ovalid  <= n_ovalid;
            r_bfirst  <= n_bfirst;
            r_bsecond <= n_bsecond;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_pi      <= n_pi;
        r_jid     <= n_jid;
        r_best    <= n_best;
        r_found   <= n_found;
        r_ofirst  <= n_ofirst;
        r_osecond <= n_osecond;
        r_odist   <= n_odist;
        r_oflow   <= n_oflow;
    end

    assign o_out_valid = r_ovalid;
    assign o_found     = r_found;
    assign o_first_id  = r_ofirst;
    assign o_second_id = r_osecond;
    assign o_dist_sq   = r_odist;
    assign o_overflow  = r_oflow;

    // inner index always ahead of outer and inside the stored set
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpbf_pkg::S_DIFF) |-> ((r_j > r_i) && (r_j < r_cnt)))
        else $error("pair indices out of order");

    // fill count never passes capacity
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    // a new result only comes out of the finish step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == cpbf_pkg::S_FIN))
        else $error("result raised outside finish step");

    // no point beat taken during the search
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != cpbf_pkg::S_IDLE) |-> !o_in_ready)
        else $error("input accepted mid-search");

endmodule
